// File: rtl/core/kicker_windup_release_sequencer_macros.svh
// Assertion macros for the kicker wind-up and release sequencer.
// Included by the top level; depends on nothing else.
`ifndef KICKER_WINDUP_RELEASE_SEQUENCER_MACROS_SVH
`define KICKER_WINDUP_RELEASE_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define KWRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// Next-cycle implication, disabled while reset is asserted.
`define KWRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define KWRS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KWRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/kwrs_pkg.sv
// Shared types, codes and constants of the kicker wind-up and release sequencer.
// Used by kwrs_cfg_regs, kwrs_step and the top level; depends on nothing.
package kwrs_pkg;

    localparam int TICK_WIDTH = 16;
    localparam int CFG_WIDTH  = 16;
    localparam int CMP_WIDTH  = (TICK_WIDTH > CFG_WIDTH + 1) ? TICK_WIDTH : CFG_WIDTH + 1;
    localparam int IDX_WIDTH  = 3;

    typedef enum logic [3:0] {
        MODE_IDLE      = 4'd0,
        MODE_MANUAL    = 4'd1,
        MODE_AUTO      = 4'd2,
        MODE_POSTWAIT  = 4'd3,
        MODE_READY     = 4'd4,
        MODE_ADDWIND   = 4'd5,
        MODE_DISENGAGE = 4'd6,
        MODE_PAWL      = 4'd7,
        MODE_ENGAGE    = 4'd8
    } t_mode;

    typedef enum logic [1:0] {
        DRV_STOP    = 2'd0,
        DRV_MANUAL  = 2'd1,
        DRV_AUTO    = 2'd2,
        DRV_REVERSE = 2'd3
    } t_drive;

    localparam logic [2:0] FN_TICK   = 3'd0;
    localparam logic [2:0] FN_WINDUP = 3'd1;
    localparam logic [2:0] FN_MANUAL = 3'd2;
    localparam logic [2:0] FN_RELEASE = 3'd3;
    localparam logic [2:0] FN_KICK   = 3'd4;

    localparam logic [IDX_WIDTH-1:0] CFG_POST_WIND_WAIT = 3'd0;
    localparam logic [IDX_WIDTH-1:0] CFG_ADD_WIND       = 3'd1;
    localparam logic [IDX_WIDTH-1:0] CFG_DOG_REL_WAIT   = 3'd2;
    localparam logic [IDX_WIDTH-1:0] CFG_MOTOR_REVERSE  = 3'd3;
    localparam logic [IDX_WIDTH-1:0] CFG_PAWL_WAIT      = 3'd4;
    localparam logic [IDX_WIDTH-1:0] CFG_DOG_REENGAGE   = 3'd5;
    localparam logic [IDX_WIDTH-1:0] CFG_ENGAGE_DONE    = 3'd6;

    localparam logic [CFG_WIDTH-1:0] RST_POST_WIND_WAIT = 16'd50;
    localparam logic [CFG_WIDTH-1:0] RST_ADD_WIND       = 16'd25;
    localparam logic [CFG_WIDTH-1:0] RST_DOG_REL_WAIT   = 16'd25;
    localparam logic [CFG_WIDTH-1:0] RST_MOTOR_REVERSE  = 16'd10;
    localparam logic [CFG_WIDTH-1:0] RST_PAWL_WAIT      = 16'd25;
    localparam logic [CFG_WIDTH-1:0] RST_DOG_REENGAGE   = 16'd100;
    localparam logic [CFG_WIDTH-1:0] RST_ENGAGE_DONE    = 16'd125;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] post_wind_wait;
        logic [CFG_WIDTH-1:0] add_wind;
        logic [CFG_WIDTH-1:0] dog_rel_wait;
        logic [CFG_WIDTH-1:0] motor_reverse;
        logic [CFG_WIDTH-1:0] pawl_wait;
        logic [CFG_WIDTH-1:0] dog_reengage;
        logic [CFG_WIDTH-1:0] engage_done;
    } t_cfg;

    typedef struct packed {
        t_mode                 mode;
        logic [TICK_WIDTH-1:0] elapsed;
        t_drive                motor;
        logic                  dog;
        logic                  pawl;
        logic                  kicked;
    } t_state;

    typedef struct packed {
        t_mode  mode;
        t_drive motor;
        logic   dog;
        logic   pawl;
        logic   kicked;
        logic   enc_clr;
    } t_result;

endpackage

// File: rtl/core/kwrs_cfg_regs.sv
// Configuration register file of the kicker sequencer: seven tick thresholds.
// Depends on kwrs_pkg.
module kwrs_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [kwrs_pkg::IDX_WIDTH-1:0]      i_index,
    input  logic [kwrs_pkg::CFG_WIDTH-1:0]      i_data,
    output kwrs_pkg::t_cfg                      o_cfg
);

    kwrs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.post_wind_wait <= kwrs_pkg::RST_POST_WIND_WAIT;
            r_cfg.add_wind       <= kwrs_pkg::RST_ADD_WIND;
            r_cfg.dog_rel_wait   <= kwrs_pkg::RST_DOG_REL_WAIT;
            r_cfg.motor_reverse  <= kwrs_pkg::RST_MOTOR_REVERSE;
            r_cfg.pawl_wait      <= kwrs_pkg::RST_PAWL_WAIT;
            r_cfg.dog_reengage   <= kwrs_pkg::RST_DOG_REENGAGE;
            r_cfg.engage_done    <= kwrs_pkg::RST_ENGAGE_DONE;
        end else if (i_we) begin
            // Indexes past the last register are dropped.
            unique case (i_index)
                kwrs_pkg::CFG_POST_WIND_WAIT: r_cfg.post_wind_wait <= i_data;
                kwrs_pkg::CFG_ADD_WIND:       r_cfg.add_wind       <= i_data;
                kwrs_pkg::CFG_DOG_REL_WAIT:   r_cfg.dog_rel_wait   <= i_data;
                kwrs_pkg::CFG_MOTOR_REVERSE:  r_cfg.motor_reverse  <= i_data;
                kwrs_pkg::CFG_PAWL_WAIT:      r_cfg.pawl_wait      <= i_data;
                kwrs_pkg::CFG_DOG_REENGAGE:   r_cfg.dog_reengage   <= i_data;
                kwrs_pkg::CFG_ENGAGE_DONE:    r_cfg.engage_done    <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/kwrs_step.sv
// Next-state logic of the kicker sequencer: one item applied to the current state.
// Purely combinational; depends on kwrs_pkg.
module kwrs_step (
    input  kwrs_pkg::t_state  i_state,
    input  kwrs_pkg::t_cfg    i_cfg,
    input  logic [2:0]        i_func,
    input  logic              i_pickup_down,
    input  logic              i_windup_done,
    output kwrs_pkg::t_state  o_state,
    output logic              o_enc_clr
);

    localparam int CW = kwrs_pkg::CMP_WIDTH;

    logic [kwrs_pkg::TICK_WIDTH-1:0] w_inc;
    logic [CW-1:0]                   w_el;
    logic [CW-1:0]                   w_rev_end;

    // Saturating increment of the elapsed counter, widened for the compares.
    assign w_inc     = (&i_state.elapsed) ? i_state.elapsed
                                          : i_state.elapsed + kwrs_pkg::TICK_WIDTH'(1);
    assign w_el      = CW'(w_inc);
    assign w_rev_end = CW'(i_cfg.dog_rel_wait) + CW'(i_cfg.motor_reverse);

    always_comb begin
        o_state   = i_state;
        o_enc_clr = 1'b0;
        unique case (i_func)
            kwrs_pkg::FN_TICK: begin
                o_state.elapsed = w_inc;
                unique case (i_state.mode)
                    kwrs_pkg::MODE_IDLE: begin
                        o_enc_clr      = 1'b1;
                        o_state.kicked = 1'b0;
                        o_state.dog    = 1'b0;
                    end
                    kwrs_pkg::MODE_MANUAL: begin
                        o_state.pawl  = 1'b1;
                        o_state.motor = kwrs_pkg::DRV_MANUAL;
                    end
                    kwrs_pkg::MODE_AUTO: begin
                        o_state.pawl  = 1'b1;
                        o_state.motor = kwrs_pkg::DRV_AUTO;
                        if (i_windup_done) begin
                            o_state.mode    = kwrs_pkg::MODE_POSTWAIT;
                            o_state.elapsed = '0;
                        end
                    end
                    kwrs_pkg::MODE_POSTWAIT: begin
                        o_state.motor = kwrs_pkg::DRV_STOP;
                        if (w_el >= CW'(i_cfg.post_wind_wait)) begin
                            o_state.pawl    = 1'b0;
                            o_state.mode    = kwrs_pkg::MODE_READY;
                            o_state.elapsed = '0;
                        end
                    end
                    kwrs_pkg::MODE_READY: begin
                    end
                    kwrs_pkg::MODE_ADDWIND: begin
                        o_state.pawl  = 1'b1;
                        o_state.motor = (w_el <= CW'(i_cfg.add_wind)) ? kwrs_pkg::DRV_MANUAL
                                                                      : kwrs_pkg::DRV_STOP;
                    end
                    kwrs_pkg::MODE_DISENGAGE: begin
                        o_state.dog = 1'b1;
                        if (w_el >= CW'(i_cfg.dog_rel_wait)) begin
                            if (w_el <= w_rev_end) begin
                                o_state.motor = kwrs_pkg::DRV_REVERSE;
                            end else begin
                                o_state.motor   = kwrs_pkg::DRV_STOP;
                                o_state.mode    = kwrs_pkg::MODE_PAWL;
                                o_state.elapsed = '0;
                            end
                        end
                    end
                    kwrs_pkg::MODE_PAWL: begin
                        o_state.pawl = 1'b1;
                        if (w_el >= CW'(i_cfg.pawl_wait)) begin
                            o_state.kicked  = 1'b1;
                            o_state.mode    = kwrs_pkg::MODE_ENGAGE;
                            o_state.elapsed = '0;
                        end
                    end
                    kwrs_pkg::MODE_ENGAGE: begin
                        if (w_el >= CW'(i_cfg.dog_reengage)) begin
                            o_state.dog = 1'b0;
                        end
                        if (w_el >= CW'(i_cfg.engage_done)) begin
                            o_state.mode    = kwrs_pkg::MODE_IDLE;
                            o_state.elapsed = '0;
                        end
                    end
                    default: begin
                        o_state.mode    = kwrs_pkg::MODE_IDLE;
                        o_state.elapsed = '0;
                    end
                endcase
            end
            kwrs_pkg::FN_WINDUP: begin
                if (i_state.mode == kwrs_pkg::MODE_IDLE) begin
                    o_state.mode    = kwrs_pkg::MODE_AUTO;
                    o_state.elapsed = '0;
                end
            end
            kwrs_pkg::FN_MANUAL: begin
                if (i_state.mode == kwrs_pkg::MODE_IDLE) begin
                    o_state.mode    = kwrs_pkg::MODE_MANUAL;
                    o_state.elapsed = '0;
                end else if (i_state.mode == kwrs_pkg::MODE_READY) begin
                    o_state.mode    = kwrs_pkg::MODE_ADDWIND;
                    o_state.elapsed = '0;
                end
            end
            kwrs_pkg::FN_RELEASE: begin
                if (i_state.mode == kwrs_pkg::MODE_MANUAL ||
                    i_state.mode == kwrs_pkg::MODE_ADDWIND) begin
                    o_state.mode    = kwrs_pkg::MODE_POSTWAIT;
                    o_state.elapsed = '0;
                end
            end
            kwrs_pkg::FN_KICK: begin
                if (i_state.mode == kwrs_pkg::MODE_READY && i_pickup_down) begin
                    o_enc_clr       = 1'b1;
                    o_state.mode    = kwrs_pkg::MODE_DISENGAGE;
                    o_state.elapsed = '0;
                end
            end
            default: begin
                // Unused function codes leave the state as it is.
            end
        endcase
    end

endmodule

// File: rtl/core/kicker_windup_release_sequencer.sv
// Top level of the spring kicker wind-up and release sequencer.
// Depends on kwrs_pkg, kwrs_cfg_regs, kwrs_step and the assertion macro header.
//
//   Channel   Direction  Handshake                  Payload
//   item in   input      i_valid / o_ready          i_func, i_pickup_down, i_windup_done
//   result    output     o_valid / i_ready          o_state_code, o_motor_drive,
//                                                   o_dog_gear_released, o_pawl_out,
//                                                   o_has_kicked, o_encoder_clear
//   config    input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each item passes through the input register and then the result register. One item
// is accepted every cycle while the result is not stalled; the state update
// is a single pass of kwrs_step between the input register and the result register.
// Reset is synchronous and returns the machine to idle with the default thresholds.
// A stalled result only holds back the input register; the input side keeps taking
// items as long as the input register can drain into the result register.
`include "kicker_windup_release_sequencer_macros.svh"

module kicker_windup_release_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Item input channel.
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [2:0]                         i_func,
    input  logic                               i_pickup_down,
    input  logic                               i_windup_done,
    // Result output channel.
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [3:0]                         o_state_code,
    output logic [1:0]                         o_motor_drive,
    output logic                               o_dog_gear_released,
    output logic                               o_pawl_out,
    output logic                               o_has_kicked,
    output logic                               o_encoder_clear,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [kwrs_pkg::IDX_WIDTH-1:0]     i_cfg_index,
    input  logic [kwrs_pkg::CFG_WIDTH-1:0]     i_cfg_data
);

    // Input register holding one accepted item.
    logic             r_in_valid;
    logic [2:0]       r_in_func;
    logic             r_in_pickup;
    logic             r_in_wdone;

    // Machine state, updated when the item in the input register moves on.
    kwrs_pkg::t_state r_state;
    kwrs_pkg::t_state n_state;
    logic             n_enc_clr;

    // Result register.
    logic              r_out_valid;
    kwrs_pkg::t_result r_out;

    kwrs_pkg::t_cfg   w_cfg;
    logic             w_out_free;
    logic             w_advance;
    logic             w_in_xfer;

    // The result register can take a new entry when it is empty or being drained.
    assign w_out_free = !r_out_valid || i_ready;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_ready    = !r_in_valid || w_out_free;
    assign w_in_xfer  = i_valid && o_ready;

    // Configuration writes are always taken; the user must write only while the block is idle (not enforced here).
    assign o_cfg_ready = 1'b1;

    kwrs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    kwrs_step u_step (
        .i_state       (r_state),
        .i_cfg         (w_cfg),
        .i_func        (r_in_func),
        .i_pickup_down (r_in_pickup),
        .i_windup_done (r_in_wdone),
        .o_state       (n_state),
        .o_enc_clr     (n_enc_clr)
    );

    // Input register: control is reset, the payload is loaded on every transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (w_in_xfer) begin
            r_in_func   <= i_func;
            r_in_pickup <= i_pickup_down;
            r_in_wdone  <= i_windup_done;
        end
    end

    // Machine state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode    <= kwrs_pkg::MODE_IDLE;
            r_state.elapsed <= '0;
            r_state.motor   <= kwrs_pkg::DRV_STOP;
            r_state.dog     <= 1'b0;
            r_state.pawl    <= 1'b0;
            r_state.kicked  <= 1'b0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Result register: the state after the update plus the encoder-clear pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (w_advance) begin
            r_out.mode    <= n_state.mode;
            r_out.motor   <= n_state.motor;
            r_out.dog     <= n_state.dog;
            r_out.pawl    <= n_state.pawl;
            r_out.kicked  <= n_state.kicked;
            r_out.enc_clr <= n_enc_clr;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_state_code        = 4'(r_out.mode);
    assign o_motor_drive       = 2'(r_out.motor);
    assign o_dog_gear_released = r_out.dog;
    assign o_pawl_out          = r_out.pawl;
    assign o_has_kicked        = r_out.kicked;
    assign o_encoder_clear     = r_out.enc_clr;

    // The mode register only ever holds one of the nine defined states.
    `KWRS_ASSERT_IMP(a_mode_legal, i_clk, i_rst_n, 1'b1,
        r_state.mode <= kwrs_pkg::MODE_ENGAGE)
    // The motor only runs in reverse while the dog gear is being disengaged.
    `KWRS_ASSERT_IMP(a_reverse_mode, i_clk, i_rst_n, r_state.motor == kwrs_pkg::DRV_REVERSE,
        r_state.mode == kwrs_pkg::MODE_DISENGAGE)
    // An encoder clear comes only from an idle tick or an accepted kick.
    `KWRS_ASSERT_IMP(a_clr_mode, i_clk, i_rst_n, r_out_valid && r_out.enc_clr,
        r_out.mode == kwrs_pkg::MODE_IDLE || r_out.mode == kwrs_pkg::MODE_DISENGAGE)
    // An item leaving the input register always lands in the result register.
    `KWRS_ASSERT_NEXT(a_advance_lands, i_clk, i_rst_n, w_advance, r_out_valid)

endmodule
